FILE: src/hidkar_pkg.sv
// Shared constants, codes and control types for the HID key action report engine.
package hidkar_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int NUM_SLOT_PORTS = 6;
    localparam int CNT_W = $clog2(KEY_SLOTS + 1);
    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;

    localparam logic [2:0] ACT_KEY      = 3'd0;
    localparam logic [2:0] ACT_MOUSE    = 3'd1;
    localparam logic [2:0] ACT_PAD      = 3'd2;
    localparam logic [2:0] ACT_CONSUMER = 3'd3;

    localparam logic [2:0] RK_WAKE     = 3'd0;
    localparam logic [2:0] RK_KEYBOARD = 3'd1;
    localparam logic [2:0] RK_KB_REL   = 3'd2;
    localparam logic [2:0] RK_MOUSE    = 3'd3;
    localparam logic [2:0] RK_PAD      = 3'd4;
    localparam logic [2:0] RK_CONSUMER = 3'd5;

    localparam int PB_WAKE     = 0;
    localparam int PB_KEYBOARD = 1;
    localparam int PB_MOUSE    = 2;
    localparam int PB_PAD      = 3;
    localparam int PB_CONSUMER = 4;
    localparam int NUM_PB      = 5;

    typedef struct packed {
        logic capture;
        logic apply_evt;
        logic idx_clr;
        logic idx_inc;
        logic shift;
        logic load_pend;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_poll;
        logic rel_start;
        logic match;
        logic idx_end;
        logic pend_any;
        logic out_free;
    } t_sts;

endpackage

FILE: src/hidkar_ctrl.sv
// Controller state machine: sequences request capture, event application, key list scan and shift, and report emission.
module hidkar_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  hidkar_pkg::t_sts i_sts,
    output hidkar_pkg::t_cmd o_cmd
);
    import hidkar_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.is_poll) begin
                    o_cmd.load_pend = 1'b1;
                    n_state = ST_EMIT;
                end else if (i_sts.rel_start) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.apply_evt = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_sts.match) begin
                    n_state = ST_SHIFT;
                end else if (i_sts.idx_end) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (!i_sts.pend_any) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: src/hidkar_dp.sv
// Datapath: key list, button masks, sent copies, pending report set and output register.
module hidkar_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hidkar_pkg::t_cmd i_cmd,
    output hidkar_pkg::t_sts o_sts,
    input  logic             i_kind,
    input  logic [1:0]       i_event_req,
    input  logic [2:0]       i_action_type,
    input  logic [7:0]       i_key_code,
    input  logic [31:0]      i_bit_mask,
    input  logic [15:0]      i_usage_code,
    input  logic             i_host_ready,
    input  logic             i_host_suspended,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_report_kind,
    output logic [7:0]       o_slot_0,
    output logic [7:0]       o_slot_1,
    output logic [7:0]       o_slot_2,
    output logic [7:0]       o_slot_3,
    output logic [7:0]       o_slot_4,
    output logic [7:0]       o_slot_5,
    output logic [31:0]      o_payload,
    output logic             o_last
);
    import hidkar_pkg::*;

    // captured request
    logic        r_kind;
    logic [1:0]  r_ev;
    logic [2:0]  r_act;
    logic [7:0]  r_code;
    logic [31:0] r_mask;
    logic [15:0] r_usage;
    logic        r_ready;
    logic        r_susp;

    // tracked state
    logic [7:0]       r_list [KEY_SLOTS];
    logic [7:0]       n_list [KEY_SLOTS];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_sent_count, n_sent_count;
    logic [7:0]       r_mouse, n_mouse;
    logic [7:0]       r_sent_mouse, n_sent_mouse;
    logic [31:0]      r_pad, n_pad;
    logic [31:0]      r_sent_pad, n_sent_pad;
    logic [15:0]      r_cons, n_cons;
    logic [15:0]      r_sent_cons, n_sent_cons;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [NUM_PB-1:0] r_pend, n_pend;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_kind, n_out_kind;
    logic [7:0]  r_out_slots [NUM_SLOT_PORTS];
    logic [7:0]  n_out_slots [NUM_SLOT_PORTS];
    logic [31:0] r_out_payload, n_out_payload;
    logic        r_out_last, n_out_last;

    logic [7:0]        w_ext [KEY_SLOTS+1];
    logic [7:0]        w_kb_slots [NUM_SLOT_PORTS];
    logic [NUM_PB-1:0] w_pick;
    logic              w_kc, w_mc, w_pc, w_cc, w_any;
    logic              w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_ev    <= i_event_req;
            r_act   <= i_action_type;
            r_code  <= i_key_code;
            r_mask  <= i_bit_mask;
            r_usage <= i_usage_code;
            r_ready <= i_host_ready;
            r_susp  <= i_host_suspended;
        end
    end

    always_comb begin
        for (int j = 0; j < KEY_SLOTS; j++) begin
            w_ext[j] = r_list[j];
        end
        w_ext[KEY_SLOTS] = 8'h00;
        for (int j = 0; j < NUM_SLOT_PORTS; j++) begin
            w_kb_slots[j] = 8'h00;
        end
        for (int j = 0; j < KEY_SLOTS && j < NUM_SLOT_PORTS; j++) begin
            w_kb_slots[j] = r_list[j];
        end
    end

    assign w_kc  = (r_count != r_sent_count);
    assign w_mc  = (r_mouse != r_sent_mouse);
    assign w_pc  = (r_pad != r_sent_pad);
    assign w_cc  = (r_cons != r_sent_cons);
    assign w_any = w_kc | w_mc | w_pc | w_cc;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_pick     = r_pend & (~r_pend + NUM_PB'(1));

    assign o_sts.is_poll   = (r_kind == KIND_POLL);
    assign o_sts.rel_start = (r_act == ACT_KEY) && (r_ev == EV_RELEASE) && (r_count != '0);
    assign o_sts.match     = (r_list[r_idx] == r_code);
    assign o_sts.idx_end   = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign o_sts.pend_any  = (r_pend != '0);
    assign o_sts.out_free  = w_out_free;

    always_comb begin
        n_list        = r_list;
        n_count       = r_count;
        n_sent_count  = r_sent_count;
        n_mouse       = r_mouse;
        n_sent_mouse  = r_sent_mouse;
        n_pad         = r_pad;
        n_sent_pad    = r_sent_pad;
        n_cons        = r_cons;
        n_sent_cons   = r_sent_cons;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_kind    = r_out_kind;
        n_out_slots   = r_out_slots;
        n_out_payload = r_out_payload;
        n_out_last    = r_out_last;

        if (i_cmd.apply_evt) begin
            unique case (r_act)
                ACT_KEY: begin
                    if (r_ev == EV_PRESS && r_count < CNT_W'(KEY_SLOTS)) begin
                        n_list[r_count[IDX_W-1:0]] = r_code;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_MOUSE: begin
                    n_mouse = (r_ev == EV_PRESS) ? (r_mouse | r_mask[7:0])
                                                 : (r_mouse & ~r_mask[7:0]);
                end
                ACT_PAD: begin
                    n_pad = (r_ev == EV_PRESS) ? (r_pad | r_mask) : (r_pad & ~r_mask);
                end
                ACT_CONSUMER: begin
                    if (r_ev == EV_PRESS) begin
                        n_cons = r_usage;
                    end else if (r_ev == EV_RELEASE) begin
                        n_cons = 16'h0000;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IDX_W'(1);
        end

        // slots past the count are always zero, so a full shift-down closes the gap
        if (i_cmd.shift) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (IDX_W'(j) >= r_idx) begin
                    n_list[j] = w_ext[j+1];
                end
            end
            n_count = r_count - CNT_W'(1);
        end

        if (i_cmd.load_pend) begin
            n_pend[PB_WAKE]     = r_susp && w_any;
            n_pend[PB_KEYBOARD] = r_ready && w_kc;
            n_pend[PB_MOUSE]    = r_ready && w_mc;
            n_pend[PB_PAD]      = r_ready && w_pc;
            n_pend[PB_CONSUMER] = r_ready && w_cc;
        end

        if (i_cmd.emit) begin
            n_pend        = r_pend & ~w_pick;
            n_out_valid   = 1'b1;
            n_out_last    = ((r_pend & ~w_pick) == '0);
            n_out_payload = 32'h0;
            for (int j = 0; j < NUM_SLOT_PORTS; j++) begin
                n_out_slots[j] = 8'h00;
            end
            priority if (w_pick[PB_WAKE]) begin
                n_out_kind = RK_WAKE;
            end else if (w_pick[PB_KEYBOARD]) begin
                if (r_count != '0) begin
                    n_out_kind  = RK_KEYBOARD;
                    n_out_slots = w_kb_slots;
                end else begin
                    n_out_kind = RK_KB_REL;
                end
                n_sent_count = r_count;
            end else if (w_pick[PB_MOUSE]) begin
                n_out_kind    = RK_MOUSE;
                n_out_payload = {24'h0, r_mouse};
                n_sent_mouse  = r_mouse;
            end else if (w_pick[PB_PAD]) begin
                n_out_kind    = RK_PAD;
                n_out_payload = r_pad;
                n_sent_pad    = r_pad;
            end else begin
                n_out_kind    = RK_CONSUMER;
                n_out_payload = {16'h0, r_cons};
                n_sent_cons   = r_cons;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < KEY_SLOTS; j++) begin
                r_list[j] <= 8'h00;
            end
            r_count      <= '0;
            r_sent_count <= '0;
            r_mouse      <= 8'h00;
            r_sent_mouse <= 8'h00;
            r_pad        <= 32'h0;
            r_sent_pad   <= 32'h0;
            r_cons       <= 16'h0;
            r_sent_cons  <= 16'h0;
            r_idx        <= '0;
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_list       <= n_list;
            r_count      <= n_count;
            r_sent_count <= n_sent_count;
            r_mouse      <= n_mouse;
            r_sent_mouse <= n_sent_mouse;
            r_pad        <= n_pad;
            r_sent_pad   <= n_sent_pad;
            r_cons       <= n_cons;
            r_sent_cons  <= n_sent_cons;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind    <= n_out_kind;
        r_out_slots   <= n_out_slots;
        r_out_payload <= n_out_payload;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_report_kind = r_out_kind;
    assign o_slot_0      = r_out_slots[0];
    assign o_slot_1      = r_out_slots[1];
    assign o_slot_2      = r_out_slots[2];
    assign o_slot_3      = r_out_slots[3];
    assign o_slot_4      = r_out_slots[4];
    assign o_slot_5      = r_out_slots[5];
    assign o_payload     = r_out_payload;
    assign o_last        = r_out_last;

endmodule

FILE: src/hid_key_action_report_engine_unit.sv
// Top level of the HID key action report engine: controller plus datapath.
// A request is captured in IDLE and decoded in the next cycle, in DECODE; an event is applied
// there, and a key release scans the list in SCAN (one slot compared per cycle), then shifts in SHIFT.
// A poll loads the pending report set in DECODE, then EMIT issues one report per cycle
// while i_out_stall is low, until no report is pending.
// One request at a time; the output register lets the last report wait while input is open.
// Reset is synchronous, active low: lists, masks, usages and sent copies clear to zero.
module hid_key_action_report_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [1:0]  i_event_req,
    input  logic [2:0]  i_action_type,
    input  logic [7:0]  i_key_code,
    input  logic [31:0] i_bit_mask,
    input  logic [15:0] i_usage_code,
    input  logic        i_host_ready,
    input  logic        i_host_suspended,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_report_kind,
    output logic [7:0]  o_slot_0,
    output logic [7:0]  o_slot_1,
    output logic [7:0]  o_slot_2,
    output logic [7:0]  o_slot_3,
    output logic [7:0]  o_slot_4,
    output logic [7:0]  o_slot_5,
    output logic [31:0] o_payload,
    output logic        o_last
);
    import hidkar_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    hidkar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hidkar_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_kind           (i_kind),
        .i_event_req      (i_event_req),
        .i_action_type    (i_action_type),
        .i_key_code       (i_key_code),
        .i_bit_mask       (i_bit_mask),
        .i_usage_code     (i_usage_code),
        .i_host_ready     (i_host_ready),
        .i_host_suspended (i_host_suspended),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_report_kind    (o_report_kind),
        .o_slot_0         (o_slot_0),
        .o_slot_1         (o_slot_1),
        .o_slot_2         (o_slot_2),
        .o_slot_3         (o_slot_3),
        .o_slot_4         (o_slot_4),
        .o_slot_5         (o_slot_5),
        .o_payload        (o_payload),
        .o_last           (o_last)
    );

endmodule

FILE: src/hidkar_chk.sv
// Port-level checker for the HID key action report engine, bound to the top level.
module hidkar_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_report_kind,
    input logic [7:0]  o_slot_0,
    input logic [7:0]  o_slot_1,
    input logic [7:0]  o_slot_2,
    input logic [7:0]  o_slot_3,
    input logic [7:0]  o_slot_4,
    input logic [7:0]  o_slot_5,
    input logic [31:0] o_payload,
    input logic        o_last
);
    import hidkar_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_report_kind)
            && $stable(o_payload) && $stable(o_last))
        else $error("stalled report changed");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request not followed by busy");

    a_slots_only_keyboard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_report_kind != RK_KEYBOARD) |->
            (o_slot_0 == 8'h00) && (o_slot_1 == 8'h00) && (o_slot_2 == 8'h00)
            && (o_slot_3 == 8'h00) && (o_slot_4 == 8'h00) && (o_slot_5 == 8'h00))
        else $error("key slots set on non-keyboard report");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_report_kind == RK_WAKE) || (o_report_kind == RK_KEYBOARD)
            || (o_report_kind == RK_KB_REL)) |-> (o_payload == 32'h0))
        else $error("payload set on wake or keyboard report");

endmodule

bind hid_key_action_report_engine_unit hidkar_chk u_chk (.*);
